/* hdl/psc_pkg.sv */
// psc_pkg: shared types and constants of the pi speed controller
// no dependencies; used by the interfaces, the top level, the checker and the bench
package psc_pkg;

	// payload types
	typedef logic        [15:0] count_t;
	typedef logic signed [16:0] speed_t;
	typedef logic        [6:0]  duty_t;
	typedef logic        [10:0] cmp_t;
	typedef logic        [7:0]  gain_t;
	typedef logic signed [15:0] setting_t;
	typedef logic        [14:0] integ_t;

	// register map, index = paddr[3:2]
	localparam int unsigned ADDR_W = 4;
	typedef enum logic [1:0] {
		REG_KP     = 2'd0,
		REG_KI     = 2'd1,
		REG_TARGET = 2'd2,
		REG_LIMIT  = 2'd3
	} reg_idx_t;

	// register reset values
	localparam gain_t    KP_RESET     = 8'd8;
	localparam gain_t    KI_RESET     = 8'd2;
	localparam setting_t TARGET_RESET = 16'sd0;
	localparam integ_t   LIMIT_RESET  = 15'd5000;

	// control law constants
	localparam speed_t   SPEED_MID    = 17'sd32767;
	localparam setting_t SETTING_HIGH = 16'sd80;
	localparam setting_t SETTING_MID  = 16'sd50;
	localparam speed_t   COUNTS_HIGH  = 17'sd64;
	localparam speed_t   COUNTS_MID   = 17'sd40;
	localparam int       DUTY_BIAS    = 45;
	localparam duty_t    DUTY_MAX     = 7'd100;

endpackage

/* hdl/psc_if.sv */
// psc_if: valid/ready channels of the pi speed controller
// depends on psc_pkg for the payload types
interface psc_in_if;
	logic            valid;
	logic            ready;
	psc_pkg::count_t encoder_count;

	modport source (output valid, output encoder_count, input ready);
	modport sink   (input valid, input encoder_count, output ready);
endinterface

interface psc_out_if;
	logic            valid;
	logic            ready;
	psc_pkg::speed_t measured_speed;
	psc_pkg::speed_t speed_error;
	psc_pkg::duty_t  duty_percent;
	psc_pkg::cmp_t   compare_value;

	modport source (output valid, output measured_speed, output speed_error,
		output duty_percent, output compare_value, input ready);
	modport sink   (input valid, input measured_speed, input speed_error,
		input duty_percent, input compare_value, output ready);
endinterface

/* hdl/pi_speed_controller.sv */
// pi_speed_controller: pi motor speed controller with clamped integral
// depends on psc_pkg and the channel interfaces in psc_if.sv
// pipeline: the input register s1, then the result register
// throughput: one word per cycle while the output is not stalled; the integral update is a registered loop
// through one 8x17 multiply, an add and a clamp between s1 and the result
// reset: valids and the integral clear, registers return to their defaults
module pi_speed_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	psc_in_if.sink                        in_ch,
	psc_out_if.source                     out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [psc_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import psc_pkg::*;

	gain_t    kp_q, ki_q;
	setting_t target_q;
	integ_t   limit_q, integral_q;
	reg_idx_t reg_idx;

	logic   valid_s1, out_valid_q, advance, load_s2;
	count_t count_s1;

	speed_t                speed, count_goal, err;
	logic signed [25:0]    ki_prod, kp_prod;
	logic signed [26:0]    integ_raw, pi_sum, pi_shift, duty_raw;
	integ_t                integ_clamp, integ_next;
	duty_t                 duty;
	cmp_t                  cmp;
	logic                  target_zero;

	// register access
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q     <= KP_RESET;
			ki_q     <= KI_RESET;
			target_q <= TARGET_RESET;
			limit_q  <= LIMIT_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_KP:     kp_q     <= pwdata[7:0];
				REG_KI:     ki_q     <= pwdata[7:0];
				REG_TARGET: target_q <= $signed(pwdata[15:0]);
				REG_LIMIT:  limit_q  <= pwdata[14:0];
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_KP:     prdata = {24'd0, kp_q};
			REG_KI:     prdata = {24'd0, ki_q};
			REG_TARGET: prdata = {16'd0, target_q};
			REG_LIMIT:  prdata = {17'd0, limit_q};
		endcase
	end

	// pipeline handshake
	assign advance     = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !valid_s1 || advance;
	assign load_s2     = valid_s1 && advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			count_s1 <= in_ch.encoder_count;
		end
	end

	// speed, count target and error
	always_comb begin
		speed = $signed({1'b0, count_s1}) - SPEED_MID;
		if (target_q >= SETTING_HIGH) begin
			count_goal = COUNTS_HIGH;
		end else if (target_q >= SETTING_MID) begin
			count_goal = COUNTS_MID;
		end else begin
			count_goal = '0;
		end
		err         = count_goal - speed;
		target_zero = (target_q == '0);
	end

	// integral update with clamp to 0..limit, cleared by a zero target
	always_comb begin
		ki_prod   = 26'($signed({1'b0, ki_q})) * 26'(err);
		integ_raw = $signed({12'd0, integral_q}) + {ki_prod[25], ki_prod};
		if (integ_raw < 0) begin
			integ_clamp = '0;
		end else if (integ_raw > $signed({12'd0, limit_q})) begin
			integ_clamp = limit_q;
		end else begin
			integ_clamp = integ_raw[14:0];
		end
		integ_next = target_zero ? '0 : integ_clamp;
	end

	// proportional term, floor shift, duty clamp and compare value
	always_comb begin
		kp_prod  = 26'($signed({1'b0, kp_q})) * 26'(err);
		pi_sum   = {kp_prod[25], kp_prod} + $signed({12'd0, integ_clamp});
		pi_shift = pi_sum >>> 4;
		duty_raw = pi_shift + 27'(DUTY_BIAS);
		if (target_zero || duty_raw < 0) begin
			duty = '0;
		end else if (duty_raw > $signed({20'd0, DUTY_MAX})) begin
			duty = DUTY_MAX;
		end else begin
			duty = duty_raw[6:0];
		end
		// duty * 1200 / 100 is duty * 12
		cmp = {1'b0, duty, 3'b000} + {2'b00, duty, 2'b00};
	end

	// integral state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s2) begin
				integral_q <= integ_next;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_s2) begin
			out_ch.measured_speed <= speed;
			out_ch.speed_error    <= err;
			out_ch.duty_percent   <= duty;
			out_ch.compare_value  <= cmp;
		end
	end

	assign out_ch.valid = out_valid_q;

endmodule

/* hdl/psc_checker.sv */
// psc_checker: port-level assertions for the pi speed controller
// depends on psc_pkg; bound to pi_speed_controller below
module psc_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            out_valid,
	input logic            out_ready,
	input psc_pkg::speed_t measured_speed,
	input psc_pkg::speed_t speed_error,
	input psc_pkg::duty_t  duty_percent,
	input psc_pkg::cmp_t   compare_value
);
	import psc_pkg::*;

	logic signed [17:0] target_sum;
	assign target_sum = {measured_speed[16], measured_speed} + {speed_error[16], speed_error};

	// a stalled word stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// duty never leaves its clamp
	a_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> duty_percent <= DUTY_MAX)
		else $error("duty above maximum");

	// compare value tracks duty
	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> compare_value == ({1'b0, duty_percent, 3'b000} + {2'b00, duty_percent, 2'b00}))
		else $error("compare value mismatch");

	// speed plus error is one of the count targets
	a_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (target_sum == 18'sd0 || target_sum == 18'sd40 || target_sum == 18'sd64))
		else $error("error and speed disagree with count target");

endmodule

bind pi_speed_controller psc_checker u_psc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.measured_speed (out_ch.measured_speed),
	.speed_error    (out_ch.speed_error),
	.duty_percent   (out_ch.duty_percent),
	.compare_value  (out_ch.compare_value)
);

/* bench/tb.sv */
// tb: self-checking bench for pi_speed_controller, random valid/ready traffic and apb setup
// depends on psc_pkg, psc_if.sv and the rtl top; predicts every output word from its own model
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import psc_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_WORDS = 1200;
	localparam int WORDS_PER_SETTING = 100;

	// one output word of the controller
	typedef struct packed {
		speed_t measured_speed;
		speed_t speed_error;
		duty_t  duty_percent;
		cmp_t   compare_value;
	} ctrl_word_t;

	// control law predictor plus queue of predicted output words
	class psc_scoreboard;
		gain_t      kp;
		gain_t      ki;
		setting_t   target;
		integ_t     limit;
		integ_t     integ;
		ctrl_word_t pending[$];
		int         errors;

		function new();
			kp     = KP_RESET;
			ki     = KI_RESET;
			target = TARGET_RESET;
			limit  = LIMIT_RESET;
			integ  = '0;
			errors = 0;
		endfunction

		// register write as seen by the block, upper bits dropped
		function void apply_reg(reg_idx_t idx, logic [31:0] v);
			case (idx)
				REG_KP:     kp     = v[7:0];
				REG_KI:     ki     = v[7:0];
				REG_TARGET: target = v[15:0];
				REG_LIMIT:  limit  = v[14:0];
				default: ;
			endcase
		endfunction

		// predict the word caused by one accepted encoder count
		function void note_word(count_t c);
			int speed;
			int counts;
			int err;
			int acc;
			int sum;
			int duty;
			ctrl_word_t w;
			speed = int'(c) - 32767;
			if (target >= SETTING_HIGH)
				counts = int'(COUNTS_HIGH);
			else if (target >= SETTING_MID)
				counts = int'(COUNTS_MID);
			else
				counts = 0;
			err = counts - speed;
			// integral update with clamp to 0..limit
			acc = int'(integ) + int'(ki) * err;
			if (acc > int'(limit))
				acc = int'(limit);
			if (acc < 0)
				acc = 0;
			// arithmetic shift rounds toward minus infinity
			sum  = int'(kp) * err + acc;
			duty = DUTY_BIAS + (sum >>> 4);
			// zero target parks the motor and clears the integral
			if (target == 0) begin
				duty = 0;
				acc  = 0;
			end
			if (duty < 0)
				duty = 0;
			if (duty > int'(DUTY_MAX))
				duty = int'(DUTY_MAX);
			integ = integ_t'(acc);
			w.measured_speed = speed_t'(speed);
			w.speed_error    = speed_t'(err);
			w.duty_percent   = duty_t'(duty);
			w.compare_value  = cmp_t'(duty * 1200 / 100);
			pending.push_back(w);
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("mismatch at %0t: %s", $time, msg);
		endtask

		// compare one accepted output word with the oldest prediction
		task check_word(ctrl_word_t got);
			ctrl_word_t w;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected word speed=%0d err=%0d duty=%0d cmp=%0d",
					got.measured_speed, got.speed_error, got.duty_percent,
					got.compare_value));
			end else begin
				w = pending.pop_front();
				if (got.measured_speed !== w.measured_speed)
					report_mismatch($sformatf("measured_speed got %0d want %0d",
						got.measured_speed, w.measured_speed));
				if (got.speed_error !== w.speed_error)
					report_mismatch($sformatf("speed_error got %0d want %0d",
						got.speed_error, w.speed_error));
				if (got.duty_percent !== w.duty_percent)
					report_mismatch($sformatf("duty_percent got %0d want %0d",
						got.duty_percent, w.duty_percent));
				if (got.compare_value !== w.compare_value)
					report_mismatch($sformatf("compare_value got %0d want %0d",
						got.compare_value, w.compare_value));
			end
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	int                  cycles;
	int                  tx_gap_max;
	int                  rx_stall_max;
	psc_scoreboard       sb;

	psc_in_if  in_ch ();
	psc_out_if out_ch ();

	pi_speed_controller i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	// apb write: setup cycle, then access cycle until pready
	task automatic reg_write(reg_idx_t idx, logic [31:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.apply_reg(idx, v);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// write all four registers, junk in the unused upper bits
	task automatic set_all(int kp, int ki, int tgt, int lim);
		logic [31:0] r;
		r = $urandom;
		reg_write(REG_KP, {r[31:8], kp[7:0]});
		r = $urandom;
		reg_write(REG_KI, {r[31:8], ki[7:0]});
		r = $urandom;
		reg_write(REG_TARGET, {r[31:16], tgt[15:0]});
		r = $urandom;
		reg_write(REG_LIMIT, {r[31:15], lim[14:0]});
	endtask

	// offer one encoder word after a random gap, returns right after acceptance
	task automatic send_word(count_t c);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.encoder_count <= c;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_word(c);
	endtask

	task automatic sender_idle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	// hold until every predicted word has come out, plus pipeline slack
	task automatic wait_drained();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic next_setting(int kp, int ki, int tgt, int lim);
		sender_idle();
		wait_drained();
		set_all(kp, ki, tgt, lim);
	endtask

	function automatic int pick3(int a, int b, int r);
		int k;
		k = $urandom_range(0, 3);
		return (k == 0) ? a : (k == 1) ? b : r;
	endfunction

	// output side: random stall before each word
	initial begin
		ctrl_word_t got;
		int stall;
		out_ch.ready = 1'b0;
		forever begin
			stall = $urandom_range(0, rx_stall_max);
			@(negedge clk);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			got.measured_speed = out_ch.measured_speed;
			got.speed_error    = out_ch.speed_error;
			got.duty_percent   = out_ch.duty_percent;
			got.compare_value  = out_ch.compare_value;
			sb.check_word(got);
		end
	end

	// main sequence
	initial begin
		int kp;
		int ki;
		int tgt;
		int lim;
		int sent;
		int in_setting;
		count_t c;
		sb           = new();
		tx_gap_max   = 11;
		rx_stall_max = 11;
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		in_ch.valid         = 1'b0;
		in_ch.encoder_count = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: zero target, duty forced to zero
		send_word(16'd0);
		send_word(16'hFFFF);
		send_word(16'd32767);

		// high target with defaults
		next_setting(8, 2, 80, 5000);
		send_word(16'd32767);
		send_word(16'd32703);
		send_word(16'd32831);
		send_word(16'd0);
		send_word(16'hFFFF);

		// largest gains, mid target, integral saturates
		next_setting(255, 255, 50, 32767);
		send_word(16'd32767);
		send_word(16'd32800);
		send_word(16'd32700);
		send_word(16'd32000);

		// negative target, zero limit, small negative sum floors down
		next_setting(1, 0, -1, 0);
		send_word(16'd32768);
		send_word(16'd32766);
		send_word(16'd32767);

		// just below high threshold, zero proportional gain, zero limit
		next_setting(0, 255, 79, 0);
		send_word(16'd32700);
		send_word(16'd32727);

		// most negative and most positive target
		next_setting(255, 0, -32768, 32767);
		send_word(16'd0);
		send_word(16'hFFFF);
		next_setting(0, 0, 32767, 1);
		send_word(16'd32703);
		send_word(16'd32704);

		// just below mid threshold
		next_setting(8, 2, 49, 5000);
		send_word(16'd32760);
		send_word(16'd32767);

		// random settings, each followed by a burst of words
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			kp  = pick3(0, 255, $urandom_range(1, 32));
			ki  = pick3(0, 255, $urandom_range(0, 8));
			case ($urandom_range(0, 9))
				0: tgt = 0;
				1: tgt = 80;
				2: tgt = 50;
				3: tgt = 79;
				4: tgt = 49;
				5: tgt = -32768;
				6: tgt = 32767;
				7: tgt = $urandom_range(0, 65535) - 32768;
				default: tgt = $urandom_range(50, 200);
			endcase
			lim = pick3(0, 32767, $urandom_range(1, 8000));
			next_setting(kp, ki, tgt, lim);
			tx_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 11;
			rx_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
			for (in_setting = 0; in_setting < WORDS_PER_SETTING; in_setting++) begin
				// sender pause until the output has caught up
				if ((sent == 40) || ($urandom_range(0, 99) == 0)) begin
					sender_idle();
					wait_drained();
				end
				if ($urandom_range(0, 3) == 0)
					c = count_t'($urandom_range(0, 65535));
				else
					c = count_t'($urandom_range(32600, 32900));
				send_word(c);
				sent++;
			end
		end
		sender_idle();

		// drain and finish
		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.report_mismatch($sformatf("%0d words never came out", sb.pending.size()));
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* sim.f */
hdl/psc_pkg.sv
hdl/psc_if.sv
hdl/pi_speed_controller.sv
hdl/psc_checker.sv
bench/tb.sv
